// File: sv/mcfb_pkg.sv
// ----------------------------------------------------------------------------
// Modbus CRC frame builder package
// Shared types, step codes and the nibble-wide CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package mcfb_pkg;

  // Item kinds on the input channel.
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // CRC-16/MODBUS start value.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Step counter width and step codes within one item.
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_HDR_BYTE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SEQ        = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ADDR       = 3'd2;
  localparam logic [STEP_W-1:0] STEP_CMD        = 3'd3;
  localparam logic [STEP_W-1:0] STEP_LEN        = 3'd4;
  localparam logic [STEP_W-1:0] STEP_HDR_CRC_LO = 3'd5;
  localparam logic [STEP_W-1:0] STEP_HDR_CRC_HI = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DATA       = 3'd0;
  localparam logic [STEP_W-1:0] STEP_PAY_CRC_LO = 3'd1;
  localparam logic [STEP_W-1:0] STEP_PAY_CRC_HI = 3'd2;

  // One accepted input transaction.
  typedef struct packed {
    logic       kind;
    logic [7:0] sequence_req;
    logic [7:0] slave_address;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } item_t;

  // One output byte of the frame.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } obyte_t;

  // Nibble lookup table for the reflected polynomial 0xA001.
  function automatic logic [15:0] nib_tab(input logic [3:0] idx);
    logic [15:0] val;
    case (idx)
      4'h0:    val = 16'h0000;
      4'h1:    val = 16'hCC01;
      4'h2:    val = 16'hD801;
      4'h3:    val = 16'h1400;
      4'h4:    val = 16'hF001;
      4'h5:    val = 16'h3C00;
      4'h6:    val = 16'h2800;
      4'h7:    val = 16'hE401;
      4'h8:    val = 16'hA001;
      4'h9:    val = 16'h6C00;
      4'hA:    val = 16'h7800;
      4'hB:    val = 16'hB401;
      4'hC:    val = 16'h5000;
      4'hD:    val = 16'h9C01;
      4'hE:    val = 16'h8801;
      default: val = 16'h4400;
    endcase
    return val;
  endfunction

  // One byte of CRC update, low nibble first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c1;
    logic [15:0] c2;
    c1 = nib_tab(b[3:0] ^ crc[3:0]) ^ {4'b0000, crc[15:4]};
    c2 = nib_tab(b[7:4] ^ c1[3:0]) ^ {4'b0000, c1[15:4]};
    return c2;
  endfunction

endpackage

// File: sv/mcfb_in_stage.sv
// ----------------------------------------------------------------------------
// Modbus CRC frame builder input stage
// Registers one input transaction and holds it until the emitter releases it.
// ----------------------------------------------------------------------------
module mcfb_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  mcfb_pkg::item_t item_i,
  output logic            valid_o,
  output mcfb_pkg::item_t item_o,
  input  logic            pop_i
);

  logic            valid_q;
  logic            valid_d;
  mcfb_pkg::item_t item_q;

  // The register takes a new transaction when empty or when emptied this cycle.
  assign ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (pop_i) begin
      valid_d = 1'b0;
    end
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: sv/mcfb_emitter.sv
// ----------------------------------------------------------------------------
// Modbus CRC frame builder emitter
// Walks the held item one byte per cycle while the output is ready, keeps the
// running CRC and the frame state, and releases the item after its last byte.
// ----------------------------------------------------------------------------
module mcfb_emitter #(
  parameter int unsigned MAX_PAYLOAD = 250
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       header_byte_i,
  input  logic             item_valid_i,
  input  mcfb_pkg::item_t  item_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output mcfb_pkg::obyte_t out_o
);

  logic [mcfb_pkg::STEP_W-1:0] step_q;
  logic [mcfb_pkg::STEP_W-1:0] step_d;
  logic [15:0]                 crc_q;
  logic [15:0]                 crc_d;
  logic                        open_q;
  logic                        open_d;
  logic [7:0]                  rem_q;
  logic [7:0]                  rem_d;

  logic [7:0]  max_len;
  logic [7:0]  len_c;
  logic [15:0] crc_base;
  logic [7:0]  data_byte;
  logic        is_data;
  logic        is_lo;
  logic        is_hi;
  logic        is_last;
  logic        is_header;
  logic        ignore;

  assign max_len   = 8'(MAX_PAYLOAD);
  assign is_header = (item_i.kind == mcfb_pkg::KIND_HEADER);

  // Clamp the requested length.
  assign len_c = (item_i.payload_length > max_len) ? max_len : item_i.payload_length;

  // A header restarts the CRC at its first byte.
  assign crc_base = (is_header && step_q == mcfb_pkg::STEP_HDR_BYTE) ?
                    mcfb_pkg::CRC_INIT : crc_q;

  // A payload with no frame open is dropped without output.
  assign ignore = !is_header && (step_q == mcfb_pkg::STEP_DATA) &&
                  (!open_q || rem_q == 8'd0);

  // Decode what the current step sends.
  always_comb begin
    data_byte = 8'd0;
    is_data   = 1'b1;
    is_lo     = 1'b0;
    is_hi     = 1'b0;
    is_last   = 1'b0;
    if (is_header) begin
      case (step_q)
        mcfb_pkg::STEP_HDR_BYTE: data_byte = header_byte_i;
        mcfb_pkg::STEP_SEQ:      data_byte = item_i.sequence_req;
        mcfb_pkg::STEP_ADDR:     data_byte = item_i.slave_address;
        mcfb_pkg::STEP_CMD:      data_byte = item_i.command;
        mcfb_pkg::STEP_LEN: begin
          data_byte = len_c;
          is_last   = (len_c != 8'd0);
        end
        mcfb_pkg::STEP_HDR_CRC_LO: begin
          is_data = 1'b0;
          is_lo   = 1'b1;
        end
        default: begin
          is_data = 1'b0;
          is_hi   = 1'b1;
          is_last = 1'b1;
        end
      endcase
    end else begin
      case (step_q)
        mcfb_pkg::STEP_DATA: begin
          data_byte = item_i.payload_byte;
          is_last   = (rem_q != 8'd1);
        end
        mcfb_pkg::STEP_PAY_CRC_LO: begin
          is_data = 1'b0;
          is_lo   = 1'b1;
        end
        default: begin
          is_data = 1'b0;
          is_hi   = 1'b1;
          is_last = 1'b1;
        end
      endcase
    end
  end

  // Sequence the bytes and update the frame state.
  always_comb begin
    step_d      = step_q;
    crc_d       = crc_q;
    open_d      = open_q;
    rem_d       = rem_q;
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    out_o.frame_byte = is_data ? data_byte : (is_lo ? crc_q[7:0] : crc_q[15:8]);
    out_o.frame_end  = is_hi;
    if (item_valid_i) begin
      if (ignore) begin
        pop_o = 1'b1;
      end else if (out_ready_i) begin
        out_valid_o = 1'b1;
        if (is_data) begin
          crc_d = mcfb_pkg::crc_byte(crc_base, data_byte);
        end
        if (is_header && step_q == mcfb_pkg::STEP_LEN) begin
          open_d = 1'b1;
          rem_d  = len_c;
        end
        if (!is_header && step_q == mcfb_pkg::STEP_DATA) begin
          rem_d = rem_q - 8'd1;
        end
        if (is_hi) begin
          crc_d  = mcfb_pkg::CRC_INIT;
          open_d = 1'b0;
          rem_d  = 8'd0;
        end
        if (is_last) begin
          step_d = '0;
          pop_o  = 1'b1;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      crc_q  <= mcfb_pkg::CRC_INIT;
      open_q <= 1'b0;
      rem_q  <= 8'd0;
    end else begin
      step_q <= step_d;
      crc_q  <= crc_d;
      open_q <= open_d;
      rem_q  <= rem_d;
    end
  end

endmodule

// File: sv/mcfb_out_stage.sv
// ----------------------------------------------------------------------------
// Modbus CRC frame builder output stage
// Output register that holds one frame byte until the sink takes it.
// ----------------------------------------------------------------------------
module mcfb_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  mcfb_pkg::obyte_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output mcfb_pkg::obyte_t data_o
);

  logic             valid_q;
  mcfb_pkg::obyte_t data_q;

  // The register loads when empty or when its byte leaves this cycle.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/modbus_crc_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// Modbus CRC frame builder
// Turns header and payload transactions into an RS-485 frame byte stream.
// ----------------------------------------------------------------------------
// A header transaction sends the configured header byte, sequence, slave
// address, command and clamped length, then the two CRC-16/MODBUS bytes
// (low first) at once when the length is zero. Each payload transaction
// sends its byte, followed by the CRC bytes after the last one; frame_end_o
// marks the CRC high byte. The output carries one byte per cycle while the
// sink is ready. An item sends 1 byte for a payload byte, 3 for the last
// payload byte, 5 or 7 for a header, and none for a payload dropped with no
// frame open. The first byte of a transaction passes the input register and
// then the output register on its way out. Write header_byte_i only while
// the block is idle.
// ----------------------------------------------------------------------------
module modbus_crc_frame_builder_unit #(
  parameter int unsigned MAX_PAYLOAD = 250
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] header_byte_i,
  // Input item channel.
  input  logic       item_valid_i,
  output logic       item_ready_o,
  input  logic       kind_i,
  input  logic [7:0] sequence_req_i,
  input  logic [7:0] slave_address_i,
  input  logic [7:0] command_i,
  input  logic [7:0] payload_length_i,
  input  logic [7:0] payload_byte_i,
  // Output byte channel.
  output logic       frame_valid_o,
  input  logic       frame_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o
);

  logic             cfg_wr;
  logic [7:0]       header_byte_q;
  mcfb_pkg::item_t  in_item;
  mcfb_pkg::item_t  held_item;
  logic             held_valid;
  logic             pop;
  logic             emit_valid;
  logic             emit_ready;
  mcfb_pkg::obyte_t emit_byte;
  mcfb_pkg::obyte_t out_byte;

  // Header byte register; a configuration transaction is always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_byte_q <= 8'd0;
    end else if (cfg_wr) begin
      header_byte_q <= header_byte_i;
    end
  end

  // Gather the input fields.
  always_comb begin
    in_item.kind           = kind_i;
    in_item.sequence_req   = sequence_req_i;
    in_item.slave_address  = slave_address_i;
    in_item.command        = command_i;
    in_item.payload_length = payload_length_i;
    in_item.payload_byte   = payload_byte_i;
  end

  mcfb_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid_i),
    .ready_o (item_ready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .item_o  (held_item),
    .pop_i   (pop)
  );

  mcfb_emitter #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .header_byte_i (header_byte_q),
    .item_valid_i  (held_valid),
    .item_i        (held_item),
    .pop_o         (pop),
    .out_ready_i   (emit_ready),
    .out_valid_o   (emit_valid),
    .out_o         (emit_byte)
  );

  mcfb_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (emit_valid),
    .ready_o (emit_ready),
    .data_i  (emit_byte),
    .valid_o (frame_valid_o),
    .ready_i (frame_ready_i),
    .data_o  (out_byte)
  );

  assign frame_byte_o = out_byte.frame_byte;
  assign frame_end_o  = out_byte.frame_end;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the Modbus CRC frame builder
// Drives header and payload transactions with bursty timing against a stalling
// byte receiver. Every frame byte and end mark is checked against a local
// frame predictor that uses a bit-serial CRC-16/MODBUS.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          MAX_LEN      = 250;
  localparam logic [7:0]  MAX_LEN_B    = 8'd250;
  localparam logic [15:0] CRC_POLY_REF = 16'hA001;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          CYCLE_LIMIT  = 400000;

  // Receiver stall patterns.
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE} rdy_mode_e;

  // Clock, reset and block ports.
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] header_byte = 8'h00;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic       kind = mcfb_pkg::KIND_HEADER;
  logic [7:0] sequence_req = 8'h00;
  logic [7:0] slave_address = 8'h00;
  logic [7:0] command = 8'h00;
  logic [7:0] payload_length = 8'h00;
  logic [7:0] payload_byte = 8'h00;
  logic       frame_valid;
  logic       frame_ready = 1'b0;
  logic [7:0] frame_byte;
  logic       frame_end;

  // Predictor state and the bytes it still expects.
  logic [7:0]       pred_header;
  logic [15:0]      pred_crc;
  logic [7:0]       pred_left;
  logic             pred_open;
  mcfb_pkg::obyte_t frame_q[$];

  // Run bookkeeping.
  int errors = 0;
  int cycle_count = 0;
  int items_taken = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int cfg_writes = 0;
  int burst_left = 0;
  int stall_left = 0;
  rdy_mode_e stall_mode = RDY_ALWAYS;

  modbus_crc_frame_builder_unit #(
    .MAX_PAYLOAD(MAX_LEN)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .header_byte_i   (header_byte),
    .item_valid_i    (item_valid),
    .item_ready_o    (item_ready),
    .kind_i          (kind),
    .sequence_req_i  (sequence_req),
    .slave_address_i (slave_address),
    .command_i       (command),
    .payload_length_i(payload_length),
    .payload_byte_i  (payload_byte),
    .frame_valid_o   (frame_valid),
    .frame_ready_i   (frame_ready),
    .frame_byte_o    (frame_byte),
    .frame_end_o     (frame_end)
  );

  always #5 clk = ~clk;

  // Bit-serial CRC-16/MODBUS update, least significant bit first.
  function automatic logic [15:0] crc16_bitwise(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REF) : (c >> 1);
    end
    return c;
  endfunction

  // Queue one frame byte and fold it into the running CRC.
  function automatic void expect_data(input logic [7:0] b);
    mcfb_pkg::obyte_t e;
    e.frame_byte = b;
    e.frame_end  = 1'b0;
    frame_q.push_back(e);
    pred_crc = crc16_bitwise(pred_crc, b);
  endfunction

  // Queue the two CRC bytes and close the frame.
  function automatic void expect_crc();
    mcfb_pkg::obyte_t e;
    e.frame_byte = pred_crc[7:0];
    e.frame_end  = 1'b0;
    frame_q.push_back(e);
    e.frame_byte = pred_crc[15:8];
    e.frame_end  = 1'b1;
    frame_q.push_back(e);
    pred_crc  = mcfb_pkg::CRC_INIT;
    pred_open = 1'b0;
    pred_left = 8'd0;
  endfunction

  // Work out the frame bytes that one accepted transaction causes.
  function automatic int predict_frame_bytes(input mcfb_pkg::item_t it);
    logic [7:0] len;
    int n;
    n = 0;
    if (it.kind == mcfb_pkg::KIND_HEADER) begin
      len = (it.payload_length > MAX_LEN_B) ? MAX_LEN_B : it.payload_length;
      pred_crc = mcfb_pkg::CRC_INIT;
      expect_data(pred_header);
      expect_data(it.sequence_req);
      expect_data(it.slave_address);
      expect_data(it.command);
      expect_data(len);
      n = 5;
      if (len == 8'd0) begin
        expect_crc();
        n = 7;
      end else begin
        pred_open = 1'b1;
        pred_left = len;
      end
    end else if (pred_open && pred_left != 8'd0) begin
      expect_data(it.payload_byte);
      n = 1;
      pred_left = pred_left - 8'd1;
      if (pred_left == 8'd0) begin
        expect_crc();
        n = 3;
      end
    end
    return n;
  endfunction

  // Header item; the payload byte field is unused and gets noise.
  function automatic mcfb_pkg::item_t hdr_item(input logic [7:0] seq, input logic [7:0] addr,
                                               input logic [7:0] cmd, input logic [7:0] len);
    mcfb_pkg::item_t it;
    it.kind           = mcfb_pkg::KIND_HEADER;
    it.sequence_req   = seq;
    it.slave_address  = addr;
    it.command        = cmd;
    it.payload_length = len;
    it.payload_byte   = 8'($urandom);
    return it;
  endfunction

  // Payload item; the header fields are unused and get noise.
  function automatic mcfb_pkg::item_t pay_item(input logic [7:0] pb);
    mcfb_pkg::item_t it;
    it.kind           = mcfb_pkg::KIND_PAYLOAD;
    it.sequence_req   = 8'($urandom);
    it.slave_address  = 8'($urandom);
    it.command        = 8'($urandom);
    it.payload_length = 8'($urandom);
    it.payload_byte   = pb;
    return it;
  endfunction

  // Send one transaction in bursts with random gaps between them.
  task automatic send_item(input mcfb_pkg::item_t it);
    int gap;
    int n;
    @(negedge clk);
    if (burst_left == 0) begin
      item_valid = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    item_valid     = 1'b1;
    kind           = it.kind;
    sequence_req   = it.sequence_req;
    slave_address  = it.slave_address;
    command        = it.command;
    payload_length = it.payload_length;
    payload_byte   = it.payload_byte;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    n = predict_frame_bytes(it);
    if (it.kind == mcfb_pkg::KIND_HEADER || n > 0) items_taken++;
  endtask

  // Hold off the sender until every expected byte has left the block.
  task automatic wait_frames_drained();
    @(negedge clk);
    item_valid = 1'b0;
    burst_left = 0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the header byte register; the caller makes sure the block is idle.
  task automatic write_header_cfg(input logic [7:0] value);
    @(negedge clk);
    cfg_valid   = 1'b1;
    header_byte = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred_header = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Field extremes, zero length, clamping, abandoned frames and stray payloads.
  task automatic test_directed();
    send_item(pay_item(8'hFF));
    send_item(hdr_item(8'h00, 8'h00, 8'h00, 8'h00));
    wait_frames_drained();
    write_header_cfg(8'hFF);
    send_item(hdr_item(8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_item(hdr_item(8'h01, 8'h11, 8'h03, 8'h01));
    send_item(pay_item(8'h00));
    send_item(pay_item(8'hA5));
    send_item(hdr_item(8'h80, 8'h7F, 8'h10, 8'h02));
    send_item(pay_item(8'hFF));
    send_item(pay_item(8'h5A));
    send_item(hdr_item(8'h55, 8'hAA, 8'h33, MAX_LEN_B));
    send_item(pay_item(8'h12));
    send_item(hdr_item(8'hAA, 8'h55, 8'hCC, 8'h03));
    send_item(pay_item(8'h01));
    send_item(pay_item(8'h80));
    send_item(pay_item(8'hFE));
    send_item(hdr_item(8'h0F, 8'hF0, 8'h3C, 8'hFF));
    send_item(pay_item(8'h77));
    send_item(hdr_item(8'hF0, 8'h0F, 8'hC3, 8'd251));
    send_item(hdr_item(8'h42, 8'h24, 8'h99, 8'h00));
    wait_frames_drained();
    write_header_cfg(8'h00);
    send_item(hdr_item(8'($urandom), 8'($urandom), 8'($urandom), 8'h01));
    send_item(pay_item(8'($urandom)));
    wait_frames_drained();
  endtask

  // One frame at the clamped maximum length, run to its end.
  task automatic test_longest_frame();
    write_header_cfg(8'h7E);
    send_item(hdr_item(8'($urandom), 8'($urandom), 8'($urandom), 8'hFF));
    for (int i = 0; i < MAX_LEN; i++) send_item(pay_item(8'($urandom)));
    send_item(pay_item(8'($urandom)));
    wait_frames_drained();
  endtask

  // Mostly well-formed frames with random content, plus stray and cut-off items.
  task automatic test_random_frames(input int phases, input int per_phase);
    int goal;
    int pick;
    int len;
    int count;
    for (int p = 0; p < phases; p++) begin
      write_header_cfg(8'($urandom));
      goal = items_taken + per_phase;
      while (items_taken < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_item(pay_item(8'($urandom)));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 60)      len = $urandom_range(0, 4);
          else if (pick < 85) len = $urandom_range(5, 16);
          else if (pick < 95) len = $urandom_range(17, 40);
          else                len = $urandom_range(251, 255);
          send_item(hdr_item(8'($urandom), 8'($urandom), 8'($urandom), 8'(len)));
          if (len > MAX_LEN) count = $urandom_range(0, 6);
          else if ($urandom_range(0, 99) < 85) count = len;
          else count = (len == 0) ? 0 : $urandom_range(0, len - 1);
          for (int i = 0; i < count; i++) send_item(pay_item(8'($urandom)));
          if (count == len && $urandom_range(0, 9) == 0) send_item(pay_item(8'($urandom)));
        end
      end
      wait_frames_drained();
    end
  endtask

  // Receiver ready pattern: stretches of always ready, coin flips and sparse.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rdy_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(4, 50);
    end
    stall_left--;
    case (stall_mode)
      RDY_ALWAYS: frame_ready = 1'b1;
      RDY_COIN:   frame_ready = 1'($urandom_range(0, 1));
      default:    frame_ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  // Compare each output transaction with the oldest expected byte.
  always @(posedge clk) begin
    mcfb_pkg::obyte_t e;
    if (rst_n && frame_valid && frame_ready) begin
      if (frame_q.size() == 0) begin
        $error("frame_byte: unexpected transaction, actual %02h frame_end %0b",
               frame_byte, frame_end);
        errors++;
      end else begin
        e = frame_q.pop_front();
        bytes_checked++;
        if (frame_byte !== e.frame_byte) begin
          $error("frame_byte mismatch: expected %02h, actual %02h", e.frame_byte, frame_byte);
          errors++;
        end
        if (frame_end !== e.frame_end) begin
          $error("frame_end mismatch: expected %0b, actual %0b", e.frame_end, frame_end);
          errors++;
        end
        if (e.frame_end) frames_closed++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("Timeout after %0d cycles, %0d bytes still expected", cycle_count, frame_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin
    pred_header = 8'h00;
    pred_crc    = mcfb_pkg::CRC_INIT;
    pred_left   = 8'd0;
    pred_open   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_longest_frame();
    test_random_frames(2, 30);
    wait_frames_drained();
    $display("Covered %0d transactions, %0d closed frames, %0d bytes checked.",
             items_taken, frames_closed, bytes_checked);
    $display("Header byte written %0d times, extremes and random values included.", cfg_writes);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
